// ----- sv/pwm_pkg.sv -----
// shared types, constants and register map of the path wildcard matcher
package pwm_pkg;

    // pattern geometry
    localparam int PATTERN_MAX   = 32;
    localparam int NUM_POS       = PATTERN_MAX + 1;
    localparam int POS_W         = $clog2(NUM_POS);
    localparam int NUM_PAT_REGS  = 4;
    localparam int NUM_REG_BYTES = 8 * NUM_PAT_REGS;
    localparam int LEN_W         = 6;

    // apb geometry
    localparam int ADDR_W = 6;
    localparam int DATA_W = 64;
    localparam int IDX_W  = 3;

    // register indexes
    localparam logic [IDX_W-1:0] REG_PAT_0  = 3'd0;
    localparam logic [IDX_W-1:0] REG_PAT_1  = 3'd1;
    localparam logic [IDX_W-1:0] REG_PAT_2  = 3'd2;
    localparam logic [IDX_W-1:0] REG_PAT_3  = 3'd3;
    localparam logic [IDX_W-1:0] REG_LEN    = 3'd4;

    // special pattern bytes
    localparam logic [7:0] STAR_CHAR  = 8'h2A;
    localparam logic [7:0] SLASH_CHAR = 8'h2F;
    localparam logic [7:0] END_CHAR   = 8'h00;

    typedef logic [NUM_POS-1:0][7:0] pat_bytes_t;
    typedef logic [NUM_POS-1:0]      pos_vec_t;

    // configuration handed from the register block to the datapath
    typedef struct packed {
        pat_bytes_t         pat;
        logic [POS_W-1:0]   len;
        logic               restart;
    } cfg_t;

    // per-cycle control broadcast to every cell
    typedef struct packed {
        logic restart;
        logic step;
    } cell_ctrl_t;

endpackage

// ----- sv/pwm_regs.sv -----
// apb register block holding the pattern bytes and the pattern length
module pwm_regs (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pwm_pkg::ADDR_W-1:0]  paddr,
    input  logic [pwm_pkg::DATA_W-1:0]  pwdata,
    output logic [pwm_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output pwm_pkg::cfg_t               cfg
);

    logic [pwm_pkg::NUM_PAT_REGS-1:0][pwm_pkg::DATA_W-1:0] pat_reg;
    logic [pwm_pkg::NUM_PAT_REGS-1:0][pwm_pkg::DATA_W-1:0] pat_next;
    logic [pwm_pkg::LEN_W-1:0]                             len_reg;
    logic [pwm_pkg::LEN_W-1:0]                             len_next;
    logic [pwm_pkg::IDX_W-1:0]                             idx;
    logic                                                  wr;

    assign pready = 1'b1;
    assign idx    = paddr[pwm_pkg::ADDR_W-1:3];
    assign wr     = psel && penable && pwrite && pready;

    // register writes
    always_comb begin
        pat_next = pat_reg;
        len_next = len_reg;
        if (wr) begin
            case (idx)
                pwm_pkg::REG_PAT_0,
                pwm_pkg::REG_PAT_1,
                pwm_pkg::REG_PAT_2,
                pwm_pkg::REG_PAT_3: pat_next[idx[1:0]] = pwdata;
                pwm_pkg::REG_LEN:   len_next = pwdata[pwm_pkg::LEN_W-1:0];
                default:            ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat_reg <= '0;
            len_reg <= '0;
        end else begin
            pat_reg <= pat_next;
            len_reg <= len_next;
        end
    end

    // read back
    always_comb begin
        case (idx)
            pwm_pkg::REG_PAT_0,
            pwm_pkg::REG_PAT_1,
            pwm_pkg::REG_PAT_2,
            pwm_pkg::REG_PAT_3: prdata = pat_reg[idx[1:0]];
            pwm_pkg::REG_LEN:   prdata = {{(pwm_pkg::DATA_W-pwm_pkg::LEN_W){1'b0}}, len_reg};
            default:            prdata = '0;
        endcase
    end

    // pattern bytes per position, zero past the registers
    always_comb begin
        for (int i = 0; i < pwm_pkg::NUM_POS; i++) begin
            if (i < pwm_pkg::NUM_REG_BYTES) begin
                cfg.pat[i] = pat_reg[2'(i >> 3)][8*(i & 7) +: 8];
            end else begin
                cfg.pat[i] = pwm_pkg::END_CHAR;
            end
        end
    end

    // clamp the length to PATTERN_MAX, the widest pattern
    always_comb begin
        // any write restarts the current path
        cfg.restart = wr;
        if (len_reg > pwm_pkg::LEN_W'(pwm_pkg::PATTERN_MAX)) begin
            cfg.len = pwm_pkg::POS_W'(pwm_pkg::PATTERN_MAX);
        end else begin
            cfg.len = pwm_pkg::POS_W'(len_reg);
        end
    end

endmodule

// ----- sv/pwm_cell.sv -----
// one pattern position: holds its active bit and forwards literal matches
module pwm_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  pwm_pkg::cell_ctrl_t ctrl,
    input  logic                init_bit,
    input  logic [7:0]          pat_char,
    input  logic                pos_en,
    input  logic [7:0]          path_char,
    input  logic                cur_bit,
    input  logic                fwd_in,
    output logic                act_bit,
    output logic                prop,
    output logic                fwd_out
);

    logic act_reg;
    logic act_next;
    logic is_star;
    logic lit_hit;
    logic keep;

    // star positions pass activity on, literals consume one byte
    assign is_star = (pat_char == pwm_pkg::STAR_CHAR);
    assign prop    = pos_en && is_star;
    assign lit_hit = pos_en && !is_star && (pat_char == path_char);
    assign fwd_out = cur_bit && lit_hit;
    assign keep    = cur_bit && prop && (path_char != pwm_pkg::SLASH_CHAR);

    always_comb begin
        act_next = act_reg;
        if (ctrl.restart) begin
            act_next = init_bit;
        end else if (ctrl.step) begin
            act_next = keep || fwd_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            act_reg <= init_bit;
        end else begin
            act_reg <= act_next;
        end
    end

    assign act_bit = act_reg;

endmodule

// ----- sv/path_wildcard_matcher_core.sv -----
// top level of the path wildcard matcher: cell row, star closure and result buffer
//
// Usage: the pattern is written over the APB port (four 64-bit byte registers at
// 0x00..0x18, length at 0x20); any write restarts the path in progress. The path
// streams in on s_tdata, one byte per request, and a zero byte ends it. For every
// zero byte one result request leaves on m_tdata bit 0 (1 = whole path matched).
// Throughput: one byte per cycle while s_tready is high; each cell updates its
// active bit on every accepted byte or restart, and the critical path is the
// star-closure carry chain across all positions followed by one byte compare in
// each cell. The result is registered in the buffer's output or second entry.
// A two-entry result buffer keeps s_tready high while one result waits; with two
// results pending and the receiver stalled, s_tready drops until m_tready returns.
// Reset (aresetn low, synchronous) clears the pattern to length zero, empties the
// result buffer and puts the active set back at the start position.
module path_wildcard_matcher_core (
    input  logic                        aclk,
    input  logic                        aresetn,
    // apb configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pwm_pkg::ADDR_W-1:0]  paddr,
    input  logic [pwm_pkg::DATA_W-1:0]  pwdata,
    output logic [pwm_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    // path bytes
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,    // [7:0] path_char
    // match results
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [7:0]                  m_tdata     // [0] matched, [7:1] zero
);

    pwm_pkg::cfg_t       cfg;
    pwm_pkg::cell_ctrl_t ctrl;
    pwm_pkg::pos_vec_t   act;
    pwm_pkg::pos_vec_t   prop;
    pwm_pkg::pos_vec_t   cur;
    logic [pwm_pkg::NUM_POS:0] fwd;
    logic [pwm_pkg::NUM_POS:0] gen_ext;
    logic [pwm_pkg::NUM_POS:0] prop_ext;
    logic [pwm_pkg::NUM_POS:0] sum;
    logic [pwm_pkg::NUM_POS:0] carry;

    logic s_acc;
    logic is_end;
    logic push;
    logic pop;
    logic matched;

    logic out_valid_reg, out_valid_next;
    logic out_data_reg,  out_data_next;
    logic skid_valid_reg, skid_valid_next;
    logic skid_data_reg,  skid_data_next;

    pwm_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // input handshake
    assign s_tready     = !skid_valid_reg;
    assign s_acc        = s_tvalid && s_tready;
    assign is_end       = (s_tdata == pwm_pkg::END_CHAR);
    assign push         = s_acc && is_end;
    assign ctrl.restart = cfg.restart || push;
    assign ctrl.step    = s_acc && !is_end;

    // star closure: a carry chain through runs of star positions
    assign prop_ext = {1'b0, prop};
    assign gen_ext  = {1'b0, act & prop};
    assign sum      = prop_ext + gen_ext;
    assign carry    = sum ^ prop_ext ^ gen_ext;
    assign cur      = act | carry[pwm_pkg::NUM_POS-1:0];
    assign matched  = cur[cfg.len];

    // row of position cells
    assign fwd[0] = 1'b0;
    for (genvar i = 0; i < pwm_pkg::NUM_POS; i++) begin : g_cell
        pwm_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (ctrl),
            .init_bit  (i == 0),
            .pat_char  (cfg.pat[i]),
            .pos_en    (pwm_pkg::POS_W'(i) < cfg.len),
            .path_char (s_tdata),
            .cur_bit   (cur[i]),
            .fwd_in    (fwd[i]),
            .act_bit   (act[i]),
            .prop      (prop[i]),
            .fwd_out   (fwd[i+1])
        );
    end

    // two-entry result buffer
    assign pop = out_valid_reg && m_tready;

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg) begin
            if (pop) begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end else if (push) begin
            if (out_valid_reg && !pop) begin
                skid_valid_next = 1'b1;
                skid_data_next  = matched;
            end else begin
                out_valid_next = 1'b1;
                out_data_next  = matched;
            end
        end else if (pop) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, out_data_reg};

    // a held second result always sits behind a valid first one
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("result buffer holds a second entry without a first");

    // a restart leaves only the start position active
    a_restart_start: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.restart |=> (act == pwm_pkg::pos_vec_t'(1)))
        else $error("active set not at start position after restart");

    // the last position never forwards a literal match off the row
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        fwd[pwm_pkg::NUM_POS] == 1'b0)
        else $error("literal match forwarded past the last position");

    // an end byte always yields a visible result next cycle
    a_end_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        push |=> m_tvalid)
        else $error("end of path accepted without a result");

endmodule

// ----- bench/path_wildcard_matcher_core_test.sv -----
// testbench for the path wildcard matcher: streams paths, predicts each match flag and checks it
module path_wildcard_matcher_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    // an index past the register list, which stores nothing
    localparam logic [pwm_pkg::IDX_W-1:0] REG_SPARE = 3'd5;

    logic                        aclk     = 1'b0;
    logic                        aresetn  = 1'b0;
    logic                        psel     = 1'b0;
    logic                        penable  = 1'b0;
    logic                        pwrite   = 1'b0;
    logic [pwm_pkg::ADDR_W-1:0]  paddr    = '0;
    logic [pwm_pkg::DATA_W-1:0]  pwdata   = '0;
    logic [pwm_pkg::DATA_W-1:0]  prdata;
    logic                        pready;
    logic                        s_tvalid = 1'b0;
    logic                        s_tready;
    logic [7:0]                  s_tdata  = '0;     // [7:0] path_char
    logic                        m_tvalid;
    logic                        m_tready = 1'b0;
    logic [7:0]                  m_tdata;           // [0] matched, [7:1] zero

    // mirror of the pattern registers and the live position set
    logic [63:0]                 pat_words [pwm_pkg::NUM_PAT_REGS];
    logic [pwm_pkg::LEN_W-1:0]   pat_count;
    pwm_pkg::pos_vec_t           live_pos;
    logic [7:0]                  pending_matches [$];
    logic [7:0]                  want_result;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int mismatch_count = 0;

    path_wildcard_matcher_core dut (.*);

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // pattern bytes in use, clamped to the widest pattern
    function automatic int used_len();
        return (pat_count > pwm_pkg::PATTERN_MAX) ? pwm_pkg::PATTERN_MAX : int'(pat_count);
    endfunction

    function automatic logic [7:0] pat_char(int i);
        if (i >= pwm_pkg::NUM_REG_BYTES)
            return 8'h00;
        return pat_words[i / 8][(i % 8) * 8 +: 8];
    endfunction

    // a live position in front of a star also makes the one behind it live
    function automatic pwm_pkg::pos_vec_t close_stars(pwm_pkg::pos_vec_t s);
        int n;
        n = used_len();
        for (int i = 0; i < n; i++)
            if (s[i] && pat_char(i) == pwm_pkg::STAR_CHAR)
                s[i + 1] = 1'b1;
        return s;
    endfunction

    // move the live set over one path byte, queue the flag on the end byte
    function automatic void advance_path(logic [7:0] c);
        pwm_pkg::pos_vec_t cur;
        pwm_pkg::pos_vec_t nxt;
        int                n;
        logic [7:0]        p;
        n   = used_len();
        cur = close_stars(live_pos);
        nxt = '0;
        if (c == pwm_pkg::END_CHAR) begin
            pending_matches.push_back({7'b0, cur[n]});
            live_pos = close_stars(pwm_pkg::pos_vec_t'(1));
        end else begin
            for (int i = 0; i < n; i++) begin
                if (cur[i]) begin
                    p = pat_char(i);
                    if (p == pwm_pkg::STAR_CHAR) begin
                        if (c != pwm_pkg::SLASH_CHAR)
                            nxt[i] = 1'b1;
                    end else if (p == c) begin
                        nxt[i + 1] = 1'b1;
                    end
                end
            end
            live_pos = close_stars(nxt);
        end
    endfunction

    // any write restarts the path in progress
    function automatic void apply_write(logic [pwm_pkg::IDX_W-1:0] idx,
                                        logic [pwm_pkg::DATA_W-1:0] val);
        if (idx < pwm_pkg::NUM_PAT_REGS)
            pat_words[idx[1:0]] = val;
        else if (idx == pwm_pkg::REG_LEN)
            pat_count = val[pwm_pkg::LEN_W-1:0];
        live_pos = close_stars(pwm_pkg::pos_vec_t'(1));
    endfunction

    function automatic logic [255:0] text_pattern(string s);
        logic [255:0] b;
        b = '0;
        for (int i = 0; i < s.len(); i++)
            b[8 * i +: 8] = s[i];
        return b;
    endfunction

    // mostly letters a to c, with stars, slashes and some random bytes so that paths get deep
    function automatic logic [7:0] glob_char();
        int r;
        r = $urandom_range(0, 9);
        if (r < 3)
            return pwm_pkg::STAR_CHAR;
        if (r == 3)
            return pwm_pkg::SLASH_CHAR;
        if (r == 4)
            return 8'($urandom_range(0, 255));
        return 8'h61 + 8'($urandom_range(0, 2));
    endfunction

    // one path byte request, with random idle cycles in front
    task automatic send_byte(logic [7:0] c);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        do @(posedge aclk); while (!s_tready);
        advance_path(c);
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
        send_byte(pwm_pkg::END_CHAR);
    endtask

    // drain every pending result, then let the pipeline settle
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_matches.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // setup then access; leaves psel high so transfers can follow back to back
    task automatic apb_xfer(logic wr, logic [pwm_pkg::IDX_W-1:0] idx,
                            logic [pwm_pkg::DATA_W-1:0] wdata,
                            output logic [pwm_pkg::DATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 3'b000};
        pwdata  <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rdata = prdata;
    endtask

    task automatic apb_idle();
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic write_reg(logic [pwm_pkg::IDX_W-1:0] idx, logic [pwm_pkg::DATA_W-1:0] val);
        logic [pwm_pkg::DATA_W-1:0] unused;
        apb_xfer(1'b1, idx, val, unused);
        apply_write(idx, val);
    endtask

    task automatic check_reg(logic [pwm_pkg::IDX_W-1:0] idx, logic [pwm_pkg::DATA_W-1:0] want);
        logic [pwm_pkg::DATA_W-1:0] got;
        apb_xfer(1'b0, idx, '0, got);
        if (got !== want) begin
            $display("%0t: register %0d expected %h actual %h", $time, idx, want, got);
            mismatch_count++;
        end
    endtask

    // load all pattern registers and the length, then read them back
    task automatic set_pattern(logic [255:0] bytes, logic [pwm_pkg::LEN_W-1:0] len);
        wait_idle();
        for (int k = 0; k < pwm_pkg::NUM_PAT_REGS; k++)
            write_reg(pwm_pkg::REG_PAT_0 + pwm_pkg::IDX_W'(k), bytes[64 * k +: 64]);
        write_reg(pwm_pkg::REG_LEN, pwm_pkg::DATA_W'(len));
        for (int k = 0; k < pwm_pkg::NUM_PAT_REGS; k++)
            check_reg(pwm_pkg::REG_PAT_0 + pwm_pkg::IDX_W'(k), bytes[64 * k +: 64]);
        check_reg(pwm_pkg::REG_LEN, pwm_pkg::DATA_W'(len));
        apb_idle();
    endtask

    // empty path against the empty pattern, then a path that cannot match it
    task automatic test_empty_after_reset();
        send_text("");
        send_text("a");
    endtask

    // star runs, stars over extreme bytes and a literal star, never over a slash
    task automatic test_star_runs();
        set_pattern(text_pattern("**"), 6'd2);
        send_text("");
        send_byte(8'hFF);
        send_byte(8'h01);
        send_byte(pwm_pkg::STAR_CHAR);
        send_byte(pwm_pkg::END_CHAR);
        send_text("/");
        set_pattern(text_pattern("a*/b"), 6'd4);
        send_text("a/b");
    endtask

    // length past the widest pattern is clamped
    task automatic test_length_clamp();
        set_pattern({32{pwm_pkg::STAR_CHAR}}, 6'd63);
        send_text("");
        send_text("q");
    endtask

    // a zero pattern byte can never be matched
    task automatic test_zero_pattern_byte();
        set_pattern(text_pattern("a"), 6'd2);
        send_text("a");
    endtask

    // a write in the middle of a path restarts it, also one that stores nothing
    task automatic test_restart_on_write();
        set_pattern(text_pattern("ab"), 6'd2);
        send_byte(8'h61);
        wait_idle();
        write_reg(pwm_pkg::REG_PAT_3, '0);
        apb_idle();
        send_text("b");
        send_byte(8'h61);
        wait_idle();
        write_reg(REG_SPARE, '1);
        apb_idle();
        send_text("ab");
    endtask

    // random patterns and paths built to match them, with some broken and some noise
    task automatic test_random_paths();
        logic [255:0]              pat;
        logic [pwm_pkg::LEN_W-1:0] len;
        logic [7:0]                path_q [$];
        logic [7:0]                pb;
        int                        n;
        int                        sent;
        int                        r;
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 71;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 71;
                end
                default: begin
                    send_idle_pct  = 8;
                    recv_stall_pct = 8;
                end
            endcase
            for (int k = 0; k < 5; k++) begin
                case (k)
                    0: len = 6'd32;
                    1: len = 6'd0;
                    2: len = pwm_pkg::LEN_W'($urandom_range(33, 63));
                    default: len = pwm_pkg::LEN_W'($urandom_range(1, 12));
                endcase
                n = (len > pwm_pkg::PATTERN_MAX) ? pwm_pkg::PATTERN_MAX : int'(len);
                for (int i = 0; i < 32; i++)
                    pat[8 * i +: 8] = (i < n) ? glob_char() : 8'($urandom_range(0, 255));
                if (phase == 3 && k == 4)
                    pat = '1;
                set_pattern(pat, len);
                sent = 0;
                while (sent < 50) begin
                    r = $urandom_range(0, 99);
                    path_q.delete();
                    if (r < 15) begin
                        repeat ($urandom_range(0, 10))
                            path_q.push_back(8'($urandom_range(1, 255)));
                    end else begin
                        for (int i = 0; i < n; i++) begin
                            pb = pat[8 * i +: 8];
                            if (pb == pwm_pkg::STAR_CHAR) begin
                                repeat ($urandom_range(0, 3))
                                    path_q.push_back(8'h61 + 8'($urandom_range(0, 3)));
                            end else begin
                                path_q.push_back((pb == 8'h00) ? 8'h7A : pb);
                            end
                        end
                        // break some of the well-formed paths
                        if (r < 35 && path_q.size() > 0)
                            path_q[$urandom_range(0, path_q.size() - 1)] =
                                8'($urandom_range(1, 255));
                        else if (r < 45)
                            path_q.push_back(8'($urandom_range(1, 255)));
                    end
                    foreach (path_q[j])
                        send_byte(path_q[j]);
                    send_byte(pwm_pkg::END_CHAR);
                    sent += path_q.size() + 1;
                end
            end
        end
    endtask

    // receiver stalls at random
    always @(posedge aclk)
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);

    // compare each result request with the oldest expected flag
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_matches.size() == 0) begin
                $display("%0t: result with nothing expected, actual %h", $time, m_tdata);
                mismatch_count++;
            end else begin
                want_result = pending_matches.pop_front();
                if (m_tdata !== want_result) begin
                    $display("%0t: match flag expected %h actual %h", $time, want_result,
                             m_tdata);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        pat_words = '{default: '0};
        pat_count = '0;
        live_pos  = close_stars(pwm_pkg::pos_vec_t'(1));
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        test_empty_after_reset();
        test_star_runs();
        test_length_clamp();
        test_zero_pattern_byte();
        test_restart_on_write();
        test_random_paths();
        wait_idle();
        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // hang guard
    initial begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
